// File: hw/rtl/rpsi_pkg.sv
`timescale 1ns / 1ps

package rpsi_pkg;

  localparam int unsigned CharWidth  = 8;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned DigitWidth = 4;

  typedef enum logic [2:0] {
    PH_SKIP   = 3'd0,
    PH_SIGNED = 3'd1,
    PH_ZERO   = 3'd2,
    PH_DIGITS = 3'd3,
    PH_STOP   = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    RX_DEC = 2'd0,
    RX_OCT = 2'd1,
    RX_HEX = 2'd2,
    RX_BIN = 2'd3
  } radix_t;

  typedef logic [CharWidth-1:0]  char_t;
  typedef logic [ValueWidth-1:0] value_t;
  typedef logic [DigitWidth-1:0] digit_t;

  localparam char_t CH_NUL     = 8'h00;
  localparam char_t CH_TAB     = 8'h09;
  localparam char_t CH_CR      = 8'h0d;
  localparam char_t CH_SPACE   = 8'h20;
  localparam char_t CH_MINUS   = 8'h2d;
  localparam char_t CH_ZERO    = 8'h30;
  localparam char_t CH_NINE    = 8'h39;
  localparam char_t CH_UPPER_A = 8'h41;
  localparam char_t CH_UPPER_B = 8'h42;
  localparam char_t CH_UPPER_F = 8'h46;
  localparam char_t CH_UPPER_X = 8'h58;
  localparam char_t CH_LOWER_A = 8'h61;
  localparam char_t CH_LOWER_B = 8'h62;
  localparam char_t CH_LOWER_F = 8'h66;
  localparam char_t CH_LOWER_X = 8'h78;

  // offsets that map a letter onto its digit value
  localparam char_t UPPER_OFFSET = 8'h37;
  localparam char_t LOWER_OFFSET = 8'h57;

  localparam digit_t BASE_DEC = 4'd10;
  localparam digit_t BASE_OCT = 4'd8;
  localparam digit_t BASE_BIN = 4'd2;

endpackage

// File: hw/rtl/radix_prefixed_string_to_integer.sv
`timescale 1ns / 1ps

// Channel   Dir  Payload (lowest bit first)           Accepted when
// s_*       in   tdata[7:0] ch                         s_tvalid && s_tready
// m_*       out  tdata[31:0] value, tuser[0] bad_input m_tvalid && m_tready
//
// One character per cycle. Parse state updates at the edge that takes the
// character; a NUL loads the result register and m_tvalid rises next cycle.
// The result register holds one value: input stalls only while it is full
// and not being taken. Synchronous active-high rst clears the parse state
// and empties the result register.

module radix_prefixed_string_to_integer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] ch
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] value
  output logic        m_tuser    // [0] bad_input
);

  rpsi_pkg::phase_t phase, phase_next;
  rpsi_pkg::radix_t radix, radix_next;
  rpsi_pkg::value_t accum, accum_next;
  logic             negative, negative_next;
  logic             failed, failed_next;

  rpsi_pkg::char_t  ch;
  rpsi_pkg::char_t  digit_wide;
  rpsi_pkg::digit_t digit;
  logic             digit_ok;
  logic             in_base;
  logic             is_white;
  logic             take;
  rpsi_pkg::value_t scaled;
  logic             s_acc;

  assign ch       = s_tdata;
  assign s_tready = !m_tvalid || m_tready;
  assign s_acc    = s_tvalid && s_tready;
  assign is_white = (ch == rpsi_pkg::CH_SPACE) ||
                    ((ch >= rpsi_pkg::CH_TAB) && (ch <= rpsi_pkg::CH_CR));

  // hex-class digit decode
  always_comb begin
    digit_ok   = 1'b1;
    digit_wide = '0;
    if ((ch >= rpsi_pkg::CH_ZERO) && (ch <= rpsi_pkg::CH_NINE)) begin
      digit_wide = ch - rpsi_pkg::CH_ZERO;
    end else if ((ch >= rpsi_pkg::CH_LOWER_A) && (ch <= rpsi_pkg::CH_LOWER_F)) begin
      digit_wide = ch - rpsi_pkg::LOWER_OFFSET;
    end else if ((ch >= rpsi_pkg::CH_UPPER_A) && (ch <= rpsi_pkg::CH_UPPER_F)) begin
      digit_wide = ch - rpsi_pkg::UPPER_OFFSET;
    end else begin
      digit_ok = 1'b0;
    end
    digit = digit_wide[rpsi_pkg::DigitWidth-1:0];
  end

  // accum * base as shifts and adds
  always_comb begin
    unique case (radix)
      rpsi_pkg::RX_DEC: begin
        scaled  = (accum << 3) + (accum << 1);
        in_base = digit < rpsi_pkg::BASE_DEC;
      end
      rpsi_pkg::RX_OCT: begin
        scaled  = accum << 3;
        in_base = digit < rpsi_pkg::BASE_OCT;
      end
      rpsi_pkg::RX_HEX: begin
        scaled  = accum << 4;
        in_base = 1'b1;
      end
      rpsi_pkg::RX_BIN: begin
        scaled  = accum << 1;
        in_base = digit < rpsi_pkg::BASE_BIN;
      end
      default: begin
        scaled  = accum;
        in_base = 1'b0;
      end
    endcase
  end

  always_comb begin
    phase_next    = phase;
    radix_next    = radix;
    accum_next    = accum;
    negative_next = negative;
    failed_next   = failed;
    take          = 1'b0;

    if (ch == rpsi_pkg::CH_NUL) begin
      phase_next    = rpsi_pkg::PH_SKIP;
      radix_next    = rpsi_pkg::RX_DEC;
      accum_next    = '0;
      negative_next = 1'b0;
      failed_next   = 1'b0;
    end else begin
      unique case (phase)
        rpsi_pkg::PH_SKIP: begin
          if (is_white) begin
            phase_next = rpsi_pkg::PH_SKIP;
          end else if (ch == rpsi_pkg::CH_MINUS) begin
            negative_next = 1'b1;
            phase_next    = rpsi_pkg::PH_SIGNED;
          end else if (ch == rpsi_pkg::CH_ZERO) begin
            radix_next = rpsi_pkg::RX_OCT;
            phase_next = rpsi_pkg::PH_ZERO;
          end else begin
            take = 1'b1;
          end
        end
        rpsi_pkg::PH_SIGNED: begin
          if (ch == rpsi_pkg::CH_ZERO) begin
            radix_next = rpsi_pkg::RX_OCT;
            phase_next = rpsi_pkg::PH_ZERO;
          end else begin
            take = 1'b1;
          end
        end
        rpsi_pkg::PH_ZERO: begin
          if ((ch == rpsi_pkg::CH_LOWER_X) || (ch == rpsi_pkg::CH_UPPER_X)) begin
            radix_next = rpsi_pkg::RX_HEX;
            phase_next = rpsi_pkg::PH_DIGITS;
          end else if ((ch == rpsi_pkg::CH_LOWER_B) || (ch == rpsi_pkg::CH_UPPER_B)) begin
            radix_next = rpsi_pkg::RX_BIN;
            phase_next = rpsi_pkg::PH_DIGITS;
          end else begin
            take = 1'b1;
          end
        end
        rpsi_pkg::PH_DIGITS: begin
          take = 1'b1;
        end
        default: begin
          phase_next = phase;
        end
      endcase

      if (take) begin
        if (digit_ok && in_base) begin
          phase_next = rpsi_pkg::PH_DIGITS;
          accum_next = scaled + rpsi_pkg::value_t'(digit);
        end else begin
          // freeze the partial value until the terminating NUL
          phase_next  = rpsi_pkg::PH_STOP;
          failed_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= rpsi_pkg::PH_SKIP;
      radix    <= rpsi_pkg::RX_DEC;
      accum    <= '0;
      negative <= 1'b0;
      failed   <= 1'b0;
    end else if (s_acc) begin
      phase    <= phase_next;
      radix    <= radix_next;
      accum    <= accum_next;
      negative <= negative_next;
      failed   <= failed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_acc && (ch == rpsi_pkg::CH_NUL)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc && (ch == rpsi_pkg::CH_NUL)) begin
      m_tdata <= negative ? (rpsi_pkg::value_t'(0) - accum) : accum;
      m_tuser <= failed;
    end
  end

`ifndef SYNTHESIS
  a_nul_emits: assert property (@(posedge clk) disable iff (rst)
    (s_acc && (s_tdata == rpsi_pkg::CH_NUL)) |=>
      (m_tvalid && (phase == rpsi_pkg::PH_SKIP) && (accum == '0) && !failed))
    else $error("NUL request did not load a result and clear the parse");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    (s_acc && (s_tdata != rpsi_pkg::CH_NUL)) |=> !m_tvalid)
    else $error("result appeared without a NUL request");

  a_stop_failed: assert property (@(posedge clk) disable iff (rst)
    (phase == rpsi_pkg::PH_STOP) == failed)
    else $error("stopped phase and failed flag disagree");

  a_radix_phase: assert property (@(posedge clk) disable iff (rst)
    (radix != rpsi_pkg::RX_DEC) |->
      ((phase == rpsi_pkg::PH_ZERO) || (phase == rpsi_pkg::PH_DIGITS) ||
       (phase == rpsi_pkg::PH_STOP)))
    else $error("radix chosen before any prefix was seen");

  a_frozen: assert property (@(posedge clk) disable iff (rst)
    ((phase == rpsi_pkg::PH_STOP) && !(s_acc && (s_tdata == rpsi_pkg::CH_NUL))) |=>
      $stable(accum))
    else $error("accumulator moved after a parse error");
`endif

endmodule

// File: dv/radix_parse_checker.sv
`timescale 1ns / 1ps

module radix_parse_checker
  import rpsi_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] ch
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // [31:0] value
  input  logic        m_tuser,   // [0] bad_input
  output int          mismatch_count,
  output int          results_outstanding
);

  localparam int HexBase    = 16;
  // not below any base, so a non-digit always stops the parse
  localparam int NotADigit  = 16;

  typedef struct packed {
    value_t value;
    logic   bad_input;
  } parse_result_t;

  phase_t        parse_phase;
  radix_t        parse_radix;
  value_t        parse_accum;
  logic          parse_negative;
  logic          parse_failed;
  parse_result_t parsed_results[$];
  parse_result_t oldest;

  initial begin
    mismatch_count      = 0;
    results_outstanding = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic clear_parse();
    parse_phase    = PH_SKIP;
    parse_radix    = RX_DEC;
    parse_accum    = '0;
    parse_negative = 1'b0;
    parse_failed   = 1'b0;
  endtask

  task automatic take_digit(input char_t c);
    int digit;
    int base;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      digit = c - CH_ZERO;
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
      digit = c - LOWER_OFFSET;
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
      digit = c - UPPER_OFFSET;
    end else begin
      digit = NotADigit;
    end
    case (parse_radix)
      RX_DEC:  base = BASE_DEC;
      RX_OCT:  base = BASE_OCT;
      RX_HEX:  base = HexBase;
      default: base = BASE_BIN;
    endcase
    parse_phase = PH_DIGITS;
    if (digit >= base) begin
      // freeze the partial value until NUL
      parse_failed = 1'b1;
      parse_phase  = PH_STOP;
    end else begin
      parse_accum = parse_accum * value_t'(base) + value_t'(digit);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_parse();
      parsed_results.delete();
    end else begin
      // check the result side first: a NUL taken now yields its result later
      if (m_tvalid && m_tready) begin
        if (parsed_results.size() == 0) begin
          report_mismatch($sformatf("result with none pending: value %0d bad_input %0b",
                                    $signed(m_tdata), m_tuser));
        end else begin
          oldest = parsed_results.pop_front();
          if (m_tdata !== oldest.value)
            report_mismatch($sformatf("value %0d, want %0d",
                                      $signed(m_tdata), $signed(oldest.value)));
          if (m_tuser !== oldest.bad_input)
            report_mismatch($sformatf("bad_input %0b, want %0b", m_tuser,
                                      oldest.bad_input));
        end
      end

      if (s_tvalid && s_tready) begin
        if (s_tdata == CH_NUL) begin
          oldest.value     = parse_negative ? -parse_accum : parse_accum;
          oldest.bad_input = parse_failed;
          parsed_results.push_back(oldest);
          clear_parse();
        end else begin
          case (parse_phase)
            PH_SKIP, PH_SIGNED: begin
              if (parse_phase == PH_SKIP &&
                  (s_tdata == CH_SPACE || (s_tdata >= CH_TAB && s_tdata <= CH_CR))) begin
                // drop leading whitespace
              end else if (parse_phase == PH_SKIP && s_tdata == CH_MINUS) begin
                parse_negative = 1'b1;
                parse_phase    = PH_SIGNED;
              end else if (s_tdata == CH_ZERO) begin
                parse_radix = RX_OCT;
                parse_phase = PH_ZERO;
              end else begin
                take_digit(s_tdata);
              end
            end
            PH_ZERO: begin
              if (s_tdata == CH_LOWER_X || s_tdata == CH_UPPER_X) begin
                parse_radix = RX_HEX;
                parse_phase = PH_DIGITS;
              end else if (s_tdata == CH_LOWER_B || s_tdata == CH_UPPER_B) begin
                parse_radix = RX_BIN;
                parse_phase = PH_DIGITS;
              end else begin
                take_digit(s_tdata);
              end
            end
            PH_DIGITS: take_digit(s_tdata);
            default: begin
              // stopped: ignore everything up to NUL
            end
          endcase
        end
      end
    end
    results_outstanding = parsed_results.size();
  end

endmodule

// File: dv/tb_radix_prefixed_string_to_integer.sv
`timescale 1ns / 1ps

module tb_radix_prefixed_string_to_integer;
  import rpsi_pkg::*;

  typedef enum int {
    SINK_OPEN,
    SINK_RANDOM,
    SINK_SPARSE
  } sink_mode_t;

  localparam int    HoldCycles  = 300;
  localparam int    TargetChars = 1280;
  localparam int    HoldAt      = 450;
  localparam int    DrainAt     = 900;
  localparam int    TailCycles  = 20;
  localparam int    HexBase     = 16;
  localparam char_t CH_TOP      = 8'hff;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic        m_tuser;

  int   mismatch_count;
  int   results_outstanding;
  int   sent_chars;
  int   burst_left;
  logic sink_hold_req;

  radix_prefixed_string_to_integer i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  radix_parse_checker i_checker (
    .clk                 (clk),
    .rst                 (rst),
    .s_tvalid            (s_tvalid),
    .s_tready            (s_tready),
    .s_tdata             (s_tdata),
    .m_tvalid            (m_tvalid),
    .m_tready            (m_tready),
    .m_tdata             (m_tdata),
    .m_tuser             (m_tuser),
    .mismatch_count      (mismatch_count),
    .results_outstanding (results_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("FAIL radix_prefixed_string_to_integer");
    $finish;
  end

  // Offer one request and wait for it to be taken; close the burst with a random gap that may be empty.
  task automatic send_char(input char_t c);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    do @(posedge clk); while (!s_tready);
    sent_chars++;
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                               : $urandom_range(0, 12);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(char_t'(s[i]));
    send_char(CH_NUL);
  endtask

  // receiver: stall pattern of its own, plus one long hold on request
  initial begin
    sink_mode_t mode;
    int         seg_left;
    mode     = SINK_OPEN;
    seg_left = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold_req) begin
        m_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        sink_hold_req = 1'b0;
      end
      if (seg_left == 0) begin
        mode     = sink_mode_t'($urandom_range(0, 2));
        seg_left = $urandom_range(10, 120);
      end
      seg_left--;
      case (mode)
        SINK_OPEN:   m_tready <= 1'b1;
        SINK_RANDOM: m_tready <= 1'($urandom_range(0, 1));
        default:     m_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  initial begin
    char_t  text[$];
    radix_t rx;
    int     base;
    int     digit;
    int     n_digits;
    bit     hold_done;
    bit     drain_done;
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    sink_hold_req = 1'b0;
    sent_chars    = 0;
    burst_left    = 0;
    hold_done     = 1'b0;
    drain_done    = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_text("");
    send_text("-");
    send_text("\t- ");          // whitespace after the sign is invalid
    send_text("0X");
    send_text("-0b12");         // digit not below the base
    send_char(CH_TOP);
    send_char(CH_NUL);
    send_text("8589934593");    // wraps to 1

    while (sent_chars < TargetChars) begin
      if (!hold_done && sent_chars >= HoldAt) begin
        sink_hold_req = 1'b1;
        hold_done     = 1'b1;
      end
      if (!drain_done && sent_chars >= DrainAt) begin
        s_tvalid <= 1'b0;
        do @(negedge clk); while (results_outstanding != 0);
        drain_done = 1'b1;
      end

      text.delete();
      if ($urandom_range(0, 9) < 8) begin
        repeat ($urandom_range(0, 2))
          text.push_back(($urandom_range(0, 2) == 0) ? CH_SPACE
                                                     : char_t'($urandom_range(CH_TAB, CH_CR)));
        if ($urandom_range(0, 2) == 0) text.push_back(CH_MINUS);
        rx = radix_t'($urandom_range(0, 3));
        case (rx)
          RX_DEC: base = BASE_DEC;
          RX_OCT: begin
            base = BASE_OCT;
            text.push_back(CH_ZERO);
          end
          RX_HEX: begin
            base = HexBase;
            text.push_back(CH_ZERO);
            text.push_back($urandom_range(0, 1) ? CH_LOWER_X : CH_UPPER_X);
          end
          default: begin
            base = BASE_BIN;
            text.push_back(CH_ZERO);
            text.push_back($urandom_range(0, 1) ? CH_LOWER_B : CH_UPPER_B);
          end
        endcase
        // long runs can push the value past 32 bits
        n_digits = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 8);
        repeat (n_digits) begin
          digit = $urandom_range(0, base - 1);
          if (digit < BASE_DEC)
            text.push_back(char_t'(CH_ZERO + digit));
          else
            text.push_back(char_t'(digit + ($urandom_range(0, 1) ? LOWER_OFFSET
                                                                  : UPPER_OFFSET)));
        end
        if (text.size() > 0 && $urandom_range(0, 4) == 0)
          text[$urandom_range(0, text.size() - 1)] = char_t'($urandom_range(1, CH_TOP));
      end else begin
        repeat ($urandom_range(0, 8)) text.push_back(char_t'($urandom_range(1, CH_TOP)));
      end

      foreach (text[i]) send_char(text[i]);
      send_char(CH_NUL);
    end

    s_tvalid <= 1'b0;
    while (results_outstanding != 0) @(negedge clk);
    repeat (TailCycles) @(negedge clk);
    if (mismatch_count == 0 && results_outstanding == 0)
      $display("PASS radix_prefixed_string_to_integer");
    else
      $display("FAIL radix_prefixed_string_to_integer");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/rpsi_pkg.sv
hw/rtl/radix_prefixed_string_to_integer.sv
dv/radix_parse_checker.sv
dv/tb_radix_prefixed_string_to_integer.sv
